### src/slnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slnc_pkg: shared types and constants of the serial line number classifier
// Character codes, result kinds, line buffer sizing and digit test.
// ----------------------------------------------------------------------------
package slnc_pkg;

  localparam int MAX_LINE = 24;
  localparam int CNT_W    = $clog2(MAX_LINE + 1);
  localparam int IDX_W    = $clog2(MAX_LINE);
  localparam int MANT_W   = 64;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_MINUS   = 8'h2d;

  localparam logic [2:0] KIND_INT  = 3'd0;
  localparam logic [2:0] KIND_DEC  = 3'd1;
  localparam logic [2:0] KIND_STR  = 3'd2;
  localparam logic [2:0] KIND_CHAR = 3'd3;
  localparam logic [2:0] KIND_FULL = 3'd4;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= (CH_ZERO + 8'd9));
  endfunction

endpackage

### src/slnc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slnc_in_if / slnc_out_if: valid/ready channels of the classifier
// Received byte channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface slnc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slnc_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      line_kind;
  logic signed [slnc_pkg::MANT_W-1:0] mantissa;
  logic [4:0]                      fraction_digits;
  logic                            too_big;
  logic [7:0]                      char_out;
  logic                            last;

  modport source (output valid, output line_kind, output mantissa,
                  output fraction_digits, output too_big, output char_out,
                  output last, input ready);
  modport sink   (input valid, input line_kind, input mantissa,
                  input fraction_digits, input too_big, input char_out,
                  input last, output ready);
endinterface

### src/slnc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slnc_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/serial_line_number_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_number_classifier: line buffer and number/string classifier
// Buffers received bytes, classifies each line at newline and emits results.
// ----------------------------------------------------------------------------
// A line full or character result is on the output the cycle after its byte.
// Integer/decimal lines walk the buffer: each buffered character takes a RAM
//   read, then one shared multiply-by-ten-and-add step, before the emit.
// String lines give one result per buffered character, each after a buffer read.
// The input is not ready during a walk. Reset clears the line state and the
//   output valid flag; buffer contents are undefined until written.
module serial_line_number_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  slnc_in_if.sink    rx_i,
  slnc_out_if.source res_o
);

  localparam int CNT_W  = slnc_pkg::CNT_W;
  localparam int IDX_W  = slnc_pkg::IDX_W;
  localparam int MANT_W = slnc_pkg::MANT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NRD   = 3'd1;
  localparam logic [2:0] ST_NACC  = 3'd2;
  localparam logic [2:0] ST_NEMIT = 3'd3;
  localparam logic [2:0] ST_SRD   = 3'd4;
  localparam logic [2:0] ST_SOUT  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] cpos_q, cpos_d;
  logic [4:0]       ccnt_q, ccnt_d;
  logic [CNT_W-1:0] odd_q, odd_d;
  logic             first_minus_q, first_minus_d;
  logic [7:0]       first_char_q, first_char_d;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  last_idx_q, last_idx_d;
  logic              neg_q, neg_d;
  logic [2:0]        kind_q, kind_d;
  logic [4:0]        frac_q, frac_d;
  logic [MANT_W-1:0] mag_q, mag_d;
  logic              big_q, big_d;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        out_kind_q, out_kind_d;
  logic [MANT_W-1:0] out_mant_q, out_mant_d;
  logic [4:0]        out_frac_q, out_frac_d;
  logic              out_big_q, out_big_d;
  logic [7:0]        out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  logic             out_free, in_ready, in_fire;
  logic [7:0]       c;
  logic             ram_we, ram_re;
  logic [7:0]       ram_rdata;

  logic [CNT_W-1:0] odd_w;
  logic             odd0, cp_nz, multi, is_dec, is_str, is_int;
  logic [CNT_W:0]   cp_plus1, frac_w;
  logic             line_neg;

  logic [MANT_W+3:0] prod;
  logic [MANT_W-1:0] limit;

  assign out_free = !out_valid_q || res_o.ready;
  assign in_ready = (state_q == ST_IDLE) && out_free;
  assign in_fire  = rx_i.valid && in_ready;
  assign c        = rx_i.rx_byte;

  assign ram_we = in_fire && (c != slnc_pkg::CH_NEWLINE)
                  && (fill_q < CNT_W'(slnc_pkg::MAX_LINE));
  assign ram_re = (state_q == ST_NRD) || (state_q == ST_SRD);

  slnc_ram #(
    .WIDTH (8),
    .DEPTH (slnc_pkg::MAX_LINE)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[IDX_W-1:0]),
    .wdata_i (c),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // line classification from the running counters
  assign line_neg = first_minus_q && (fill_q != '0);
  assign odd_w    = odd_q - CNT_W'(line_neg);
  assign odd0     = (odd_w == '0);
  assign cp_nz    = (cpos_q != '0);
  assign multi    = (fill_q > CNT_W'(1));
  assign is_dec   = odd0 && cp_nz && (ccnt_q == 5'd1);
  assign is_str   = (odd0 && cp_nz) || (!odd0 && multi);
  assign is_int   = odd0;
  assign cp_plus1 = {1'b0, cpos_q} + (CNT_W+1)'(1);
  assign frac_w   = ({1'b0, fill_q} > cp_plus1) ? ({1'b0, fill_q} - cp_plus1) : '0;

  // shared step: mag * 10 + digit, checked against the saturation limit
  assign prod  = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1)
                 + (MANT_W+4)'(ram_rdata - slnc_pkg::CH_ZERO);
  assign limit = neg_q ? {1'b1, {(MANT_W-1){1'b0}}} : {1'b0, {(MANT_W-1){1'b1}}};

  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    cpos_d        = cpos_q;
    ccnt_d        = ccnt_q;
    odd_d         = odd_q;
    first_minus_d = first_minus_q;
    first_char_d  = first_char_q;
    idx_d         = idx_q;
    last_idx_d    = last_idx_q;
    neg_d         = neg_q;
    kind_d        = kind_q;
    frac_d        = frac_q;
    mag_d         = mag_q;
    big_d         = big_q;

    out_valid_d = out_valid_q && !res_o.ready;
    out_kind_d  = out_kind_q;
    out_mant_d  = out_mant_q;
    out_frac_d  = out_frac_q;
    out_big_d   = out_big_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (c != slnc_pkg::CH_NEWLINE) begin
            if (c == slnc_pkg::CH_COMMA) begin
              if (ccnt_q != 5'd31) begin
                ccnt_d = ccnt_q + 5'd1;
              end
              cpos_d = fill_q;
            end
            if (ram_we) begin
              fill_d = fill_q + CNT_W'(1);
              if (!slnc_pkg::is_digit(c) && (c != slnc_pkg::CH_COMMA)) begin
                odd_d = odd_q + CNT_W'(1);
              end
              if (fill_q == '0) begin
                first_minus_d = (c == slnc_pkg::CH_MINUS);
                first_char_d  = c;
              end
            end else begin
              out_valid_d = 1'b1;
              out_kind_d  = slnc_pkg::KIND_FULL;
              out_mant_d  = '0;
              out_frac_d  = '0;
              out_big_d   = 1'b0;
              out_char_d  = '0;
              out_last_d  = 1'b1;
            end
          end else begin
            if (fill_q != '0) begin
              last_idx_d = IDX_W'(fill_q - CNT_W'(1));
              mag_d      = '0;
              big_d      = 1'b0;
              neg_d      = line_neg;
              if (is_dec || (!is_str && is_int)) begin
                kind_d = is_dec ? slnc_pkg::KIND_DEC : slnc_pkg::KIND_INT;
                frac_d = is_dec ? frac_w[4:0] : 5'd0;
                idx_d  = line_neg ? IDX_W'(1) : '0;
                // a lone minus has no digits to walk
                state_d = (line_neg && !multi) ? ST_NEMIT : ST_NRD;
              end else if (is_str) begin
                idx_d   = '0;
                state_d = ST_SRD;
              end else begin
                out_valid_d = 1'b1;
                out_kind_d  = slnc_pkg::KIND_CHAR;
                out_mant_d  = '0;
                out_frac_d  = '0;
                out_big_d   = 1'b0;
                out_char_d  = first_char_q;
                out_last_d  = 1'b1;
              end
            end
            fill_d        = '0;
            cpos_d        = '0;
            ccnt_d        = '0;
            odd_d         = '0;
            first_minus_d = 1'b0;
          end
        end
      end
      ST_NRD: begin
        state_d = ST_NACC;
      end
      ST_NACC: begin
        if (slnc_pkg::is_digit(ram_rdata) && !big_q) begin
          if (prod > {4'b0, limit}) begin
            big_d = 1'b1;
            mag_d = limit;
          end else begin
            mag_d = prod[MANT_W-1:0];
          end
        end
        if (idx_q == last_idx_q) begin
          state_d = ST_NEMIT;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_NRD;
        end
      end
      ST_NEMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_mant_d  = neg_q ? ('0 - mag_q) : mag_q;
          out_frac_d  = frac_q;
          out_big_d   = big_q;
          out_char_d  = '0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_SRD: begin
        state_d = ST_SOUT;
      end
      ST_SOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = slnc_pkg::KIND_STR;
          out_mant_d  = '0;
          out_frac_d  = '0;
          out_big_d   = 1'b0;
          out_char_d  = ram_rdata;
          out_last_d  = (idx_q == last_idx_q);
          if (idx_q == last_idx_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_SRD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fill_q        <= '0;
      cpos_q        <= '0;
      ccnt_q        <= '0;
      odd_q         <= '0;
      first_minus_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      fill_q        <= fill_d;
      cpos_q        <= cpos_d;
      ccnt_q        <= ccnt_d;
      odd_q         <= odd_d;
      first_minus_q <= first_minus_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_char_q <= first_char_d;
    idx_q        <= idx_d;
    last_idx_q   <= last_idx_d;
    neg_q        <= neg_d;
    kind_q       <= kind_d;
    frac_q       <= frac_d;
    mag_q        <= mag_d;
    big_q        <= big_d;
    out_kind_q   <= out_kind_d;
    out_mant_q   <= out_mant_d;
    out_frac_q   <= out_frac_d;
    out_big_q    <= out_big_d;
    out_char_q   <= out_char_d;
    out_last_q   <= out_last_d;
  end

  assign rx_i.ready            = in_ready;
  assign res_o.valid           = out_valid_q;
  assign res_o.line_kind       = out_kind_q;
  assign res_o.mantissa        = out_mant_q;
  assign res_o.fraction_digits = out_frac_q;
  assign res_o.too_big         = out_big_q;
  assign res_o.char_out        = out_char_q;
  assign res_o.last            = out_last_q;

endmodule

### src/slnc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slnc_checker: port-level assertions for the classifier
// Output beat stability, ready coupling and result field consistency.
// ----------------------------------------------------------------------------
module slnc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [2:0]                  line_kind_i,
  input logic [slnc_pkg::MANT_W-1:0] mantissa_i,
  input logic [4:0]                  fraction_digits_i,
  input logic [7:0]                  char_out_i,
  input logic                        last_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(line_kind_i)
      && $stable(mantissa_i) && $stable(char_out_i) && $stable(last_i))
    else $error("result beat changed while stalled");

  // input is taken only when the output slot is free or draining
  a_ready_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> out_ready_i)
    else $error("input ready while output slot is blocked");

  // only string runs span several beats
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (line_kind_i != slnc_pkg::KIND_STR) |-> last_i)
    else $error("non-string result without last");

  // fraction digits appear only on decimals
  a_frac_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (line_kind_i != slnc_pkg::KIND_DEC) |-> fraction_digits_i == 5'd0)
    else $error("fraction digits on a non-decimal result");

endmodule

bind serial_line_number_classifier slnc_checker u_slnc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (rx_i.ready),
  .out_valid_i       (res_o.valid),
  .out_ready_i       (res_o.ready),
  .line_kind_i       (res_o.line_kind),
  .mantissa_i        (res_o.mantissa),
  .fraction_digits_i (res_o.fraction_digits),
  .char_out_i        (res_o.char_out),
  .last_i            (res_o.last)
);

### sim/slnc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slnc_result_checker: scoreboard for the serial line number classifier
// Watches the byte and result channels. It keeps its own line buffer and
// comma tracking, predicts the results of each accepted byte, and compares
// every accepted result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module slnc_result_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rx_valid_i,
  input  logic                               rx_ready_i,
  input  logic [7:0]                         rx_byte_i,
  input  logic                               res_valid_i,
  input  logic                               res_ready_i,
  input  logic [2:0]                         line_kind_i,
  input  logic signed [slnc_pkg::MANT_W-1:0] mantissa_i,
  input  logic [4:0]                         fraction_digits_i,
  input  logic                               too_big_i,
  input  logic [7:0]                         char_out_i,
  input  logic                               last_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o
);

  typedef struct {
    logic [2:0]                         kind;
    logic signed [slnc_pkg::MANT_W-1:0] mant;
    logic [4:0]                         frac;
    logic                               big;
    logic [7:0]                         ch;
    logic                               last;
  } line_result_t;

  logic [7:0]                 line_buf [slnc_pkg::MAX_LINE];
  logic [slnc_pkg::CNT_W-1:0] line_len;
  logic [slnc_pkg::CNT_W-1:0] comma_at;
  logic [4:0]                 commas_seen;
  line_result_t               line_results_q [$];
  line_result_t               want;
  int unsigned                mismatches;

  function automatic bit is_numeral(input logic [7:0] c);
    return (c >= slnc_pkg::CH_ZERO) && (c <= slnc_pkg::CH_ZERO + 8'd9);
  endfunction

  // All digits of the line, comma and leading minus skipped; saturates.
  function automatic logic [slnc_pkg::MANT_W-1:0] line_value(input bit neg,
                                                             output logic sat);
    logic [slnc_pkg::MANT_W-1:0] limit;
    logic [slnc_pkg::MANT_W-1:0] mag;
    logic [slnc_pkg::MANT_W-1:0] d;
    int                          i;
    limit = neg ? {1'b1, {(slnc_pkg::MANT_W-1){1'b0}}}
                : {1'b0, {(slnc_pkg::MANT_W-1){1'b1}}};
    mag   = '0;
    sat   = 1'b0;
    for (i = neg ? 1 : 0; i < int'(line_len); i++) begin
      if (is_numeral(line_buf[i]) && !sat) begin
        d = slnc_pkg::MANT_W'(line_buf[i]) - slnc_pkg::MANT_W'(slnc_pkg::CH_ZERO);
        if (mag > (limit - d) / 10) begin
          sat = 1'b1;
          mag = limit;
        end else begin
          mag = mag * 10 + d;
        end
      end
    end
    return neg ? -mag : mag;
  endfunction

  task automatic predict_line(input logic [7:0] c);
    line_result_t r;
    int unsigned  odd;
    int           i;
    bit           neg;
    logic         sat;
    r = '{slnc_pkg::KIND_INT, '0, 5'd0, 1'b0, 8'h00, 1'b1};
    if (c != slnc_pkg::CH_NEWLINE) begin
      if (c == slnc_pkg::CH_COMMA) begin
        if (commas_seen != 5'd31) commas_seen++;
        comma_at = line_len;
      end
      if (line_len < slnc_pkg::MAX_LINE) begin
        line_buf[line_len] = c;
        line_len++;
      end else begin
        r.kind = slnc_pkg::KIND_FULL;
        line_results_q.push_back(r);
      end
    end else if (line_len != 0) begin
      odd = 0;
      for (i = 0; i < int'(line_len); i++)
        if (!is_numeral(line_buf[i]) && line_buf[i] != slnc_pkg::CH_COMMA) odd++;
      neg = (line_buf[0] == slnc_pkg::CH_MINUS);
      if (neg) odd--;
      if (odd == 0 && comma_at != 0 && commas_seen == 5'd1) begin
        r.kind = slnc_pkg::KIND_DEC;
        r.mant = line_value(neg, sat);
        r.big  = sat;
        if (line_len > comma_at + 1) r.frac = line_len - comma_at - 5'd1;
        line_results_q.push_back(r);
      end else if ((odd == 0 && comma_at != 0) || (odd != 0 && line_len > 1)) begin
        // one beat per buffered character
        r.kind = slnc_pkg::KIND_STR;
        for (i = 0; i < int'(line_len); i++) begin
          r.ch   = line_buf[i];
          r.last = (i + 1 == int'(line_len));
          line_results_q.push_back(r);
        end
      end else if (odd == 0) begin
        r.mant = line_value(neg, sat);
        r.big  = sat;
        line_results_q.push_back(r);
      end else begin
        r.kind = slnc_pkg::KIND_CHAR;
        r.ch   = line_buf[0];
        line_results_q.push_back(r);
      end
    end
    if (c == slnc_pkg::CH_NEWLINE) begin
      line_len    = '0;
      comma_at    = '0;
      commas_seen = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len    = '0;
      comma_at    = '0;
      commas_seen = '0;
      mismatches  = 0;
      line_results_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (line_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%t: unexpected result beat: kind %0d mantissa %0d frac %0d",
                      " too_big %0b char %02h last %0b"},
                     $time, line_kind_i, mantissa_i, fraction_digits_i,
                     too_big_i, char_out_i, last_i);
        end else begin
          want = line_results_q.pop_front();
          if (line_kind_i !== want.kind || mantissa_i !== want.mant ||
              fraction_digits_i !== want.frac || too_big_i !== want.big ||
              char_out_i !== want.ch || last_i !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%t: result mismatch (expected/actual): kind %0d/%0d",
                        " mantissa %0d/%0d frac %0d/%0d too_big %0b/%0b",
                        " char %02h/%02h last %0b/%0b"},
                       $time, want.kind, line_kind_i, want.mant, mantissa_i,
                       want.frac, fraction_digits_i, want.big, too_big_i,
                       want.ch, char_out_i, want.last, last_i);
          end
        end
      end
      if (rx_valid_i && rx_ready_i) predict_line(rx_byte_i);
      fail_count_o <= mismatches;
      pending_o    <= line_results_q.size();
    end
  end

endmodule

### sim/serial_line_number_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_number_classifier_tb: stimulus and verdict for the classifier
// Sends a short directed set of lines, then random lines (numbers, decimals,
// overflowing values, strings, single characters, overlong lines, noise)
// with random gaps and receiver stalls; the checker scores the results.
// ----------------------------------------------------------------------------
module serial_line_number_classifier_tb;

  localparam int RANDOM_BYTES   = 440;
  localparam int HOLD_AT_BEAT   = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {
    SHAPE_INT, SHAPE_DEC, SHAPE_BIG, SHAPE_STR,
    SHAPE_CHAR, SHAPE_FULL, SHAPE_NOISE, SHAPE_EMPTY
  } line_shape_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  bit          rx_idle_on;
  logic [7:0]  line_bytes [$];

  string big_text [8] = '{
    "9223372036854775807", "9223372036854775808", "-9223372036854775808",
    "-9223372036854775809", "18446744073709551616", "-99999999999999999999999",
    "922337203685477580,7", "-9,22337203685477580999"
  };

  slnc_in_if  rx_ch ();
  slnc_out_if res_ch ();

  serial_line_number_classifier u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  slnc_result_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rx_valid_i        (rx_ch.valid),
    .rx_ready_i        (rx_ch.ready),
    .rx_byte_i         (rx_ch.rx_byte),
    .res_valid_i       (res_ch.valid),
    .res_ready_i       (res_ch.ready),
    .line_kind_i       (res_ch.line_kind),
    .mantissa_i        (res_ch.mantissa),
    .fraction_digits_i (res_ch.fraction_digits),
    .too_big_i         (res_ch.too_big),
    .char_out_i        (res_ch.char_out),
    .last_i            (res_ch.last),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [7:0] digit_char();
    return slnc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == slnc_pkg::CH_NEWLINE) ? ~slnc_pkg::CH_NEWLINE : b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = rx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk_i); while (!rx_ch.ready);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_results_drained();
    rx_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Byte source
  initial begin
    int unsigned random_sent;
    int unsigned n_lines;
    int unsigned sel;
    int          n;
    int          a;
    int          k;
    line_shape_e shape;
    string       s;

    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    rst_ni        <= 1'b0;
    rx_idle_on    = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero, lone minus, empty line, single char, negative decimal,
    // leading comma, repeated commas, high/low bytes as a string
    send_text("0\n-\n\nx\n-9,5\n,7\n1,2,\n");
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(slnc_pkg::CH_NEWLINE);
    wait_results_drained();

    random_sent = 0;
    n_lines     = 0;
    while (random_sent < RANDOM_BYTES) begin
      if (n_lines == 0) begin
        shape = SHAPE_FULL;
      end else if (n_lines == 1) begin
        shape = SHAPE_BIG;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 22)      shape = SHAPE_INT;
        else if (sel < 42) shape = SHAPE_DEC;
        else if (sel < 50) shape = SHAPE_BIG;
        else if (sel < 67) shape = SHAPE_STR;
        else if (sel < 75) shape = SHAPE_CHAR;
        else if (sel < 85) shape = SHAPE_FULL;
        else if (sel < 95) shape = SHAPE_NOISE;
        else               shape = SHAPE_EMPTY;
      end

      line_bytes.delete();
      case (shape)
        SHAPE_INT: begin
          if ($urandom_range(0, 3) == 0) line_bytes.push_back(slnc_pkg::CH_MINUS);
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 23) : $urandom_range(1, 6);
          repeat (n) line_bytes.push_back(digit_char());
          line_bytes.push_back(slnc_pkg::CH_NEWLINE);
        end
        SHAPE_DEC: begin
          // no digits before the comma covers the leading comma case
          if ($urandom_range(0, 3) == 0) line_bytes.push_back(slnc_pkg::CH_MINUS);
          a = $urandom_range(0, 10);
          n = $urandom_range(0, 12);
          repeat (a) line_bytes.push_back(digit_char());
          line_bytes.push_back(slnc_pkg::CH_COMMA);
          repeat (n) line_bytes.push_back(digit_char());
          line_bytes.push_back(slnc_pkg::CH_NEWLINE);
        end
        SHAPE_BIG: begin
          s = big_text[$urandom_range(0, 7)];
          for (k = 0; k < s.len(); k++) line_bytes.push_back(s[k]);
          line_bytes.push_back(slnc_pkg::CH_NEWLINE);
        end
        SHAPE_STR: begin
          n = $urandom_range(2, 12);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0:       line_bytes.push_back(digit_char());
              1:       line_bytes.push_back(slnc_pkg::CH_COMMA);
              2:       line_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
              default: line_bytes.push_back(any_but_newline());
            endcase
          end
          line_bytes.push_back(slnc_pkg::CH_NEWLINE);
        end
        SHAPE_CHAR: begin
          line_bytes.push_back(any_but_newline());
          line_bytes.push_back(slnc_pkg::CH_NEWLINE);
        end
        SHAPE_FULL: begin
          // overlong line: bytes past the buffer give line full notices
          n = $urandom_range(slnc_pkg::MAX_LINE, slnc_pkg::MAX_LINE + 6);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0, 1:    line_bytes.push_back(digit_char());
              2:       line_bytes.push_back(slnc_pkg::CH_COMMA);
              default: line_bytes.push_back(any_but_newline());
            endcase
          end
          line_bytes.push_back(slnc_pkg::CH_NEWLINE);
        end
        SHAPE_NOISE: begin
          n = $urandom_range(1, 5);
          repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: line_bytes.push_back(slnc_pkg::CH_NEWLINE);
      endcase

      rx_idle_on = ($urandom_range(0, 3) != 0);
      foreach (line_bytes[k]) send_byte(line_bytes[k]);
      random_sent += line_bytes.size();
      n_lines++;
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result sink: random stalls, stall-free stretches, one long hold-off
  initial begin
    int unsigned gap;
    int unsigned beats;
    bit          idle_on;
    res_ch.ready <= 1'b0;
    beats   = 0;
    idle_on = 1'b1;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (beats % 16 == 0) idle_on = ($urandom_range(0, 2) != 0);
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (beats == HOLD_AT_BEAT) gap = HOLD_CYCLES;
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      beats++;
    end
  end

  // Watchdog on cycles with no beat on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
